FILE: design/cwmf_pkg.sv
`default_nettype none
package cwmf_pkg;

  localparam int PIX_W        = 8;
  localparam int BIT_W        = $clog2(PIX_W);
  localparam int MAX_RADIUS_D = 7;
  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RAD_REG_W    = 3;
  localparam int WID_REG_W    = 11;
  localparam int HGT_REG_W    = 13;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic             frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    SEL_IDLE,
    SEL_SETUP,
    SEL_ROWBACK,
    SEL_SCAN,
    SEL_DRAIN,
    SEL_DECIDE,
    SEL_HOLD
  } sel_state_t;

endpackage
`default_nettype wire

FILE: design/cwmf_store.sv
`default_nettype none
module cwmf_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: design/cwmf_select.sv
`default_nettype none
module cwmf_select #(
  parameter int MAX_RADIUS = 7,
  parameter int DEPTH      = 16,
  parameter int AW         = 4,
  parameter int RW         = 3,
  parameter int WW         = 11,
  parameter int HW         = 13
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [HW-1:0]                job_row,
  input  wire logic [WW-1:0]                job_col,
  input  wire logic [AW-1:0]                job_ptr,
  input  wire logic [RW-1:0]                rad,
  input  wire logic [WW-1:0]                width,
  input  wire logic [HW-1:0]                height,
  input  wire logic                         res_ready,
  output logic      [AW-1:0]                rd_addr,
  input  wire logic [cwmf_pkg::PIX_W-1:0]   rd_data,
  output logic                              busy,
  output logic                              done,
  output logic      [cwmf_pkg::PIX_W-1:0]   result
);
  import cwmf_pkg::*;

  localparam int NW = $clog2(2 * MAX_RADIUS + 2);
  localparam int CW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

  sel_state_t state_r, state_nxt;

  logic [HW-1:0]    row_r;
  logic [WW-1:0]    col_r;
  logic [AW-1:0]    ptr_r;
  logic [NW-1:0]    nx_r, ny_r, xcnt_r, ycnt_r;
  logic [AW-1:0]    addr_r, row_addr_r, start_addr_r;
  logic [BIT_W-1:0] bit_r;
  logic [PIX_W-1:0] med_r;
  logic [CW-1:0]    bound_r, cnt_r;
  logic             rdv_r;

  // clipped window extents around the job position
  logic [RW-1:0]   dy, dyb, dx, dxb;
  logic [HW-1:0]   rows_below;
  logic [WW-1:0]   cols_right;
  logic [NW-1:0]   ny_c, nx_c;
  logic [2*NW-1:0] area_c;

  always_comb begin
    rows_below = height - row_r - HW'(1);
    cols_right = width - col_r - WW'(1);
    dy  = (row_r >= HW'(rad)) ? rad : RW'(row_r);
    dx  = (col_r >= WW'(rad)) ? rad : RW'(col_r);
    dyb = (rows_below >= HW'(rad)) ? rad : RW'(rows_below);
    dxb = (cols_right >= WW'(rad)) ? rad : RW'(cols_right);
    ny_c = NW'(dy) + NW'(dyb) + NW'(1);
    nx_c = NW'(dx) + NW'(dxb) + NW'(1);
    area_c = (2*NW)'(ny_c) * (2*NW)'(nx_c);
  end

  function automatic logic [AW-1:0] wsub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + (AW+1)'(DEPTH) - {1'b0, b});
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wadd(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // pixel takes part in this bit's count when its upper bits match the prefix and the bit is 0
  logic [PIX_W:0] hi_mask;
  logic           match;

  always_comb begin
    hi_mask = ~(((PIX_W+1)'(2) << bit_r) - (PIX_W+1)'(1));
    match = ((((PIX_W+1)'(rd_data) ^ (PIX_W+1)'(med_r)) & hi_mask) == '0) && !rd_data[bit_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEL_IDLE:    if (start) state_nxt = SEL_SETUP;
      SEL_SETUP:   state_nxt = SEL_ROWBACK;
      SEL_ROWBACK: if (ycnt_r == '0) state_nxt = SEL_SCAN;
      SEL_SCAN:    if (xcnt_r == '0 && ycnt_r == '0) state_nxt = SEL_DRAIN;
      SEL_DRAIN:   state_nxt = SEL_DECIDE;
      SEL_DECIDE:  state_nxt = (bit_r == '0) ? SEL_HOLD : SEL_SCAN;
      SEL_HOLD:    if (res_ready) state_nxt = SEL_IDLE;
      default:     state_nxt = SEL_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_r != SEL_IDLE);
    done    = (state_r == SEL_HOLD) && res_ready;
    result  = med_r;
    rd_addr = addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == SEL_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (rdv_r && match) begin
      cnt_r <= cnt_r + CW'(1);
    end
    unique case (state_r)
      SEL_IDLE: begin
        if (start) begin
          row_r <= job_row;
          col_r <= job_col;
          ptr_r <= job_ptr;
        end
      end
      SEL_SETUP: begin
        addr_r  <= wsub(ptr_r, AW'(dx));
        ycnt_r  <= NW'(dy);
        nx_r    <= nx_c;
        ny_r    <= ny_c;
        bound_r <= CW'(area_c >> 1);
        bit_r   <= BIT_W'(PIX_W - 1);
        med_r   <= '0;
        cnt_r   <= '0;
      end
      SEL_ROWBACK: begin
        if (ycnt_r == '0) begin
          start_addr_r <= addr_r;
          row_addr_r   <= addr_r;
          xcnt_r       <= nx_r - NW'(1);
          ycnt_r       <= ny_r - NW'(1);
        end else begin
          addr_r <= wsub(addr_r, AW'(width));
          ycnt_r <= ycnt_r - NW'(1);
        end
      end
      SEL_SCAN: begin
        if (xcnt_r != '0) begin
          addr_r <= wadd(addr_r, AW'(1));
          xcnt_r <= xcnt_r - NW'(1);
        end else if (ycnt_r != '0) begin
          addr_r     <= wadd(row_addr_r, AW'(width));
          row_addr_r <= wadd(row_addr_r, AW'(width));
          xcnt_r     <= nx_r - NW'(1);
          ycnt_r     <= ycnt_r - NW'(1);
        end
      end
      SEL_DRAIN: begin
      end
      SEL_DECIDE: begin
        if (bound_r >= cnt_r) begin
          med_r[bit_r] <= 1'b1;
          bound_r      <= bound_r - cnt_r;
        end
        cnt_r      <= '0;
        bit_r      <= bit_r - BIT_W'(1);
        addr_r     <= start_addr_r;
        row_addr_r <= start_addr_r;
        xcnt_r     <= nx_r - NW'(1);
        ycnt_r     <= ny_r - NW'(1);
      end
      SEL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/clipped_window_median_filter_top.sv
`default_nettype none
// Square median filter with windows clipped at the frame edges. Pixels enter
// in raster order; output k leaves once input k + radius*frame_width + radius
// has been taken, and after the last pixel each further word (flush or push)
// releases one more output. A write to the radius, width or height register
// restarts the frame. The median is found one bit per pass, MSB first, by
// counting window pixels that match the prefix; each pass reads the clipped
// window (up to 225 pixels at radius 7) through the single read port of the
// row store. Words that release no output do not hold off the next word. An
// input word is held off while a median is being worked out; one finished
// word may wait at the output while the next input is taken.
module clipped_window_median_filter_top #(
  parameter int MAX_RADIUS = cwmf_pkg::MAX_RADIUS_D,
  parameter int MAX_WIDTH  = cwmf_pkg::MAX_WIDTH_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cwmf_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cwmf_pkg::out_item_t                out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cwmf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [cwmf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic      [cwmf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import cwmf_pkg::*;

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int IW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [RAD_REG_W-1:0] radius_r;
  logic [WID_REG_W-1:0] width_r;
  logic [HGT_REG_W-1:0] height_r;

  logic [RW-1:0] rad_c;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [IW-1:0] lag_c;

  always_comb begin
    if (radius_r == '0) rad_c = RW'(1);
    else if (int'(radius_r) > MAX_RADIUS) rad_c = RW'(MAX_RADIUS);
    else rad_c = RW'(radius_r);
    if (width_r == '0) w_c = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
    else w_c = WW'(width_r);
    if (height_r == '0) h_c = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
    else h_c = HW'(height_r);
    lag_c = IW'(IW'(rad_c) * IW'(w_c)) + IW'(rad_c);
  end

  // configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RADIUS: cfg_prdata = DATA_W'(radius_r);
      REG_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  logic cfg_hit;
  assign cfg_hit = cfg_wr && (cfg_paddr[3:2] == REG_RADIUS || cfg_paddr[3:2] == REG_WIDTH
                              || cfg_paddr[3:2] == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_REG_W'(1);
      width_r  <= WID_REG_W'(1024);
      height_r <= HGT_REG_W'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_REG_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[WID_REG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[HGT_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster bookkeeping
  logic [WW-1:0] in_col_r, out_col_r;
  logic [HW-1:0] in_row_r, out_row_r;
  logic [AW-1:0] in_ptr_r, out_ptr_r;
  logic [IW-1:0] pending_r;

  logic sel_busy, sel_done;
  logic [PIX_W-1:0] sel_result;
  logic [AW-1:0] rd_addr;
  logic [PIX_W-1:0] rd_data;

  logic accept, in_done, push, emit, last;
  logic [IW-1:0] pend_up;

  always_comb begin
    in_stall = sel_busy;
    accept   = in_valid && !in_stall;
    in_done  = (in_row_r == h_c);
    push     = accept && (in_data.operation == OP_PUSH) && !in_done;
    pend_up  = pending_r + IW'(1);
    emit     = accept && (out_row_r != h_c) && (push ? (pend_up > lag_c) : in_done);
    last     = (out_row_r == h_c - HW'(1)) && (out_col_r == w_c - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit || (emit && last)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      in_ptr_r  <= '0;
      out_ptr_r <= '0;
      pending_r <= '0;
    end else begin
      if (push) begin
        in_ptr_r <= (in_ptr_r == AW'(DEPTH - 1)) ? '0 : in_ptr_r + AW'(1);
        if (in_col_r + WW'(1) >= w_c) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + HW'(1);
        end else begin
          in_col_r <= in_col_r + WW'(1);
        end
      end
      if (emit) begin
        out_ptr_r <= (out_ptr_r == AW'(DEPTH - 1)) ? '0 : out_ptr_r + AW'(1);
        if (out_col_r + WW'(1) >= w_c) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + HW'(1);
        end else begin
          out_col_r <= out_col_r + WW'(1);
        end
      end
      if (push && !emit) begin
        pending_r <= pend_up;
      end else if (!push && emit) begin
        pending_r <= pending_r - IW'(1);
      end
    end
  end

  logic job_last_r;
  always_ff @(posedge clk) begin
    if (emit) begin
      job_last_r <= last;
    end
  end

  // output word register
  logic out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sel_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_done) begin
      out_data_r.filtered_value <= sel_result;
      out_data_r.frame_last     <= job_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cwmf_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (in_ptr_r),
    .wr_data (in_data.pixel_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cwmf_select #(
    .MAX_RADIUS (MAX_RADIUS),
    .DEPTH      (DEPTH),
    .AW         (AW),
    .RW         (RW),
    .WW         (WW),
    .HW         (HW)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit),
    .job_row   (out_row_r),
    .job_col   (out_col_r),
    .job_ptr   (out_ptr_r),
    .rad       (rad_c),
    .width     (w_c),
    .height    (h_c),
    .res_ready (!out_valid_r || !out_stall),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (sel_busy),
    .done      (sel_done),
    .result    (sel_result)
  );

endmodule
`default_nettype wire
